/* hdl/i2cbm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared constants for the I2C target byte memory: event codes, address
// layout and the default memory size.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    // default memory size in bytes
    localparam int MEM_BYTES_DEFAULT = 8192;

    // bus event codes carried on func
    localparam logic [1:0] FUNC_WR_START = 2'd0;
    localparam logic [1:0] FUNC_RX_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_RD_BYTE  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    // the high address byte occupies bits 15:8 of the 16-bit address
    localparam logic [16:0] HIGH_BYTE_MASK = 17'h0FF00;

endpackage

/* hdl/i2cbm_ram.sv */
// ----------------------------------------------------------------------------
// i2cbm_ram
// Generic single-port synchronous RAM, one read or write per cycle, with
// registered read data.
// ----------------------------------------------------------------------------
module i2cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write, or read with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/i2c_target_byte_memory.sv */
// ----------------------------------------------------------------------------
// i2c_target_byte_memory
// Byte memory behind an I2C target with a 16-bit address, EEPROM style.
// ----------------------------------------------------------------------------
// After reset the block clears its memory, one byte per cycle, over all
// MEM_BYTES addresses; busy stays high for that whole pass. Then a request
// is taken when start is high and busy is low. A write-transfer start, a
// received byte or an unused code strobes done in the cycle after the
// request. A read request moves the block to ST_READ, where busy is high
// and the registered output of the single-port memory is loaded; done
// then strobes from the done register with the byte. Every request gives
// exactly one result, shown for one cycle with done; the receiver must take
// it then, as it cannot hold results off. The first two received bytes after
// a write-transfer start form the address, high byte first; an address at or
// beyond MEM_BYTES is parked at an out-of-range marker where stores are
// dropped and reads return 0.
// ----------------------------------------------------------------------------
module i2c_target_byte_memory #(
    parameter int MEM_BYTES = i2cbm_pkg::MEM_BYTES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] func,
    input  logic [7:0] rx_byte,
    output logic       done,
    output logic [7:0] read_data,
    output logic       read_valid
);

    import i2cbm_pkg::*;

    localparam int AW    = $clog2(MEM_BYTES);
    localparam int PTR_W = $clog2(MEM_BYTES + 1);
    localparam logic [16:0]      MEM_LIMIT = 17'(MEM_BYTES);
    localparam logic [PTR_W-1:0] PTR_MARK  = PTR_W'(MEM_BYTES);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(MEM_BYTES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             addr_phase_reg, addr_phase_next;
    logic             addr_seen_reg, addr_seen_next;
    logic             read_oor_reg, read_oor_next;
    logic             done_reg, done_next;
    logic [7:0]       read_data_reg, read_data_next;
    logic             read_valid_reg, read_valid_next;

    logic             accept;
    logic             ptr_in_range;
    logic [16:0]      addr_hi;
    logic [16:0]      addr_lo;
    logic [PTR_W:0]   ptr_inc;
    logic [PTR_W-1:0] ptr_adv;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    assign accept       = start && (state_reg == ST_IDLE);
    assign busy         = (state_reg != ST_IDLE);
    assign ptr_in_range = (ptr_reg < PTR_MARK);

    // address bytes, and the pointer advanced with wrap at the end
    assign addr_hi = {1'b0, rx_byte, 8'h00} & HIGH_BYTE_MASK;
    assign addr_lo = 17'(ptr_reg) | {9'd0, rx_byte};
    assign ptr_inc = {1'b0, ptr_reg} + (PTR_W + 1)'(1);
    assign ptr_adv = (ptr_inc >= (PTR_W + 1)'(MEM_BYTES)) ? '0 : ptr_inc[PTR_W-1:0];

    // memory port: clear sweep, byte store or read
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = ptr_reg[AW-1:0];
        ram_wdata = rx_byte;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (accept && (func == FUNC_RX_BYTE) && !addr_phase_reg && ptr_in_range)
        begin
            ram_we = 1'b1;
        end
    end

    // control and result sequencing
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        ptr_next        = ptr_reg;
        addr_phase_next = addr_phase_reg;
        addr_seen_next  = addr_seen_reg;
        read_oor_next   = read_oor_reg;
        done_next       = 1'b0;
        read_data_next  = read_data_reg;
        read_valid_next = read_valid_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    read_data_next  = '0;
                    read_valid_next = 1'b0;
                    unique case (func)
                        FUNC_WR_START:
                        begin
                            addr_seen_next  = 1'b0;
                            addr_phase_next = 1'b1;
                            done_next       = 1'b1;
                        end
                        FUNC_RX_BYTE:
                        begin
                            done_next = 1'b1;
                            if (addr_phase_reg && !addr_seen_reg)
                            begin
                                ptr_next       = (addr_hi >= MEM_LIMIT) ? PTR_MARK
                                                                         : addr_hi[PTR_W-1:0];
                                addr_seen_next = 1'b1;
                            end
                            else if (addr_phase_reg)
                            begin
                                ptr_next        = (addr_lo >= MEM_LIMIT) ? PTR_MARK
                                                                          : addr_lo[PTR_W-1:0];
                                addr_seen_next  = 1'b0;
                                addr_phase_next = 1'b0;
                            end
                            else
                            begin
                                ptr_next = ptr_adv;
                            end
                        end
                        FUNC_RD_BYTE:
                        begin
                            read_oor_next = !ptr_in_range;
                            ptr_next      = ptr_adv;
                            state_next    = ST_READ;
                        end
                        FUNC_UNUSED:
                        begin
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                read_data_next  = read_oor_reg ? 8'd0 : ram_rdata;
                read_valid_next = 1'b1;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            ptr_reg        <= '0;
            addr_phase_reg <= 1'b1;
            addr_seen_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            ptr_reg        <= ptr_next;
            addr_phase_reg <= addr_phase_next;
            addr_seen_reg  <= addr_seen_next;
            done_reg       <= done_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        read_oor_reg   <= read_oor_next;
        read_data_reg  <= read_data_next;
        read_valid_reg <= read_valid_next;
    end

    i2cbm_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign done       = done_reg;
    assign read_data  = read_data_reg;
    assign read_valid = read_valid_reg;

    // pointer never passes the out-of-range marker
    assert property (@(posedge clk) disable iff (!rst_n) ptr_reg <= PTR_MARK)
        else $error("pointer beyond out-of-range marker");

    // a read request is answered, after the ST_READ state, with a valid byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_RD_BYTE)) |-> ##2 (done && read_valid))
        else $error("read request not answered");

    // any other request answers in the next cycle without read_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func != FUNC_RD_BYTE)) |=> (done && !read_valid))
        else $error("non-read request not answered");

    // no result while the memory is still being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done)
        else $error("result during clear sweep");

endmodule

/* tb/i2c_target_byte_memory_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_target_byte_memory_tb
// Drives bus events (write-transfer start, received bytes, read requests and
// the unused code) into the byte memory and checks every reply against a
// mirror of the memory, the address pointer and the address phase. Directed
// requests cover the corners, then random write, read and noise bursts
// follow under three sender idle settings.
// ----------------------------------------------------------------------------
module i2c_target_byte_memory_tb;
    import i2cbm_pkg::*;

    localparam int MEM_BYTES = MEM_BYTES_DEFAULT;
    localparam int AW        = $clog2(MEM_BYTES);
    localparam int ITEMS     = 2000;

    // one reply of the block
    typedef struct {
        logic [7:0] data;
        logic       valid;
    } reply_t;

    // mirror of the memory state and the replies it still owes
    class memory_mirror;
        logic [7:0]  bytes [MEM_BYTES];
        logic [16:0] ptr;
        bit          addr_phase;
        bit          high_seen;
        reply_t      due_replies [$];
        int          errors;

        function new();
            foreach (bytes[i])
                bytes[i] = 8'h00;
            ptr        = '0;
            addr_phase = 1'b1;
            high_seen  = 1'b0;
            errors     = 0;
        endfunction

        // pointer advance with wrap at the end of the memory
        function void step_pointer();
            ptr = ptr + 17'd1;
            if (ptr >= MEM_BYTES)
                ptr = '0;
        endfunction

        // apply one accepted request and queue the reply it causes
        function void note_request(logic [1:0] f, logic [7:0] b);
            reply_t r;
            r.data  = 8'h00;
            r.valid = 1'b0;
            case (f)
                FUNC_WR_START:
                begin
                    high_seen  = 1'b0;
                    addr_phase = 1'b1;
                end
                FUNC_RX_BYTE:
                begin
                    if (addr_phase)
                    begin
                        if (!high_seen)
                        begin
                            ptr       = {1'b0, b, 8'h00} & HIGH_BYTE_MASK;
                            high_seen = 1'b1;
                        end
                        else
                        begin
                            ptr        = ptr | {9'd0, b};
                            high_seen  = 1'b0;
                            addr_phase = 1'b0;
                        end
                        // park out-of-range addresses at the marker
                        if (ptr >= MEM_BYTES)
                            ptr = 17'(MEM_BYTES);
                    end
                    else
                    begin
                        if (ptr < MEM_BYTES)
                            bytes[ptr[AW-1:0]] = b;
                        step_pointer();
                    end
                end
                FUNC_RD_BYTE:
                begin
                    if (ptr < MEM_BYTES)
                        r.data = bytes[ptr[AW-1:0]];
                    r.valid = 1'b1;
                    step_pointer();
                end
                default:
                begin
                end
            endcase
            due_replies.push_back(r);
        endfunction

        // compare one reply with the oldest owed one
        function void check_reply(logic [7:0] d, logic v);
            reply_t r;
            if (due_replies.size() == 0)
            begin
                $error("unexpected reply: read_data %0h read_valid %0b", d, v);
                errors++;
                return;
            end
            r = due_replies.pop_front();
            if (d !== r.data)
            begin
                $error("read_data: expected %0h, got %0h", r.data, d);
                errors++;
            end
            if (v !== r.valid)
            begin
                $error("read_valid: expected %0b, got %0b", r.valid, v);
                errors++;
            end
        endfunction

        function int outstanding();
            return due_replies.size();
        endfunction
    endclass

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       start   = 1'b0;
    logic [1:0] func    = FUNC_WR_START;
    logic [7:0] rx_byte = 8'h00;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       read_valid;

    memory_mirror mirror = new();
    int           sent     = 0;
    int           idle_pct = 0;

    i2c_target_byte_memory u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .rx_byte    (rx_byte),
        .done       (done),
        .read_data  (read_data),
        .read_valid (read_valid)
    );

    // clock
    always #5 clk = ~clk;

    // reply check first, since a reply in the same cycle is for an older request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                mirror.check_reply(read_data, read_valid);
            if (start && !busy)
                mirror.note_request(func, rx_byte);
        end
    end

    // present one request and hold it until taken, then maybe idle
    task automatic send(input logic [1:0] f, input logic [7:0] b);
        start   <= 1'b1;
        func    <= f;
        rx_byte <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    // write-transfer start followed by both address bytes
    task automatic set_address(input logic [7:0] hi, input logic [7:0] lo);
        send(FUNC_WR_START, 8'($urandom_range(0, 255)));
        send(FUNC_RX_BYTE, hi);
        send(FUNC_RX_BYTE, lo);
    endtask

    // stop requesting until every owed reply has come back
    task automatic drain();
        start <= 1'b0;
        while (mirror.outstanding() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // high address byte, mostly in a small window so reads find written data
    function automatic logic [7:0] pick_high();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 8'($urandom_range(0, 1));
        else if (r < 90)
            return 8'h1F;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // one random burst: write, read, or noise
    task automatic random_burst();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        n    = $urandom_range(1, 12);
        if (kind < 55)
        begin
            set_address(pick_high(), 8'($urandom_range(0, 255)));
            repeat (n)
                send(FUNC_RX_BYTE, 8'($urandom_range(0, 255)));
        end
        else if (kind < 85)
        begin
            if ($urandom_range(0, 3) != 0)
                set_address(pick_high(), 8'($urandom_range(0, 255)));
            repeat (n)
                send(FUNC_RD_BYTE, 8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat (n)
                send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    // stimulus
    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // corner requests with no idling
        send(FUNC_RD_BYTE, 8'hFF);
        send(FUNC_UNUSED, 8'hFF);
        set_address(8'h00, 8'h00);
        send(FUNC_RX_BYTE, 8'hFF);
        send(FUNC_RX_BYTE, 8'h00);
        send(FUNC_RX_BYTE, 8'hA5);
        // store at the last byte wraps the pointer to zero
        set_address(8'h1F, 8'hFF);
        send(FUNC_RX_BYTE, 8'h5A);
        send(FUNC_RD_BYTE, 8'h00);
        // first out-of-range address: store dropped
        set_address(8'h20, 8'h00);
        send(FUNC_RX_BYTE, 8'h3C);
        send(FUNC_RD_BYTE, 8'h00);
        // clamped high byte stays at the marker, read returns zero
        set_address(8'hFF, 8'h00);
        send(FUNC_RD_BYTE, 8'hFF);
        // read between the two address bytes
        send(FUNC_WR_START, 8'h00);
        send(FUNC_RX_BYTE, 8'h00);
        send(FUNC_RD_BYTE, 8'h00);
        send(FUNC_RX_BYTE, 8'h02);
        send(FUNC_RD_BYTE, 8'h00);
        drain();

        // random bursts under three idle settings, fully drained in between
        idle_pct = 11;
        while (sent < ITEMS / 3)
            random_burst();
        drain();
        idle_pct = 72;
        while (sent < 2 * ITEMS / 3)
            random_burst();
        drain();
        idle_pct = 0;
        while (sent < ITEMS)
            random_burst();

        drain();
        repeat (20)
            @(posedge clk);
        if (mirror.errors == 0 && mirror.outstanding() == 0)
            $display("i2c_target_byte_memory_tb: clean");
        else
            $display("i2c_target_byte_memory_tb: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("i2c_target_byte_memory_tb: errors");
        $finish;
    end

endmodule

/* i2c_target_byte_memory.f */
hdl/i2cbm_pkg.sv
hdl/i2cbm_ram.sv
hdl/i2c_target_byte_memory.sv
tb/i2c_target_byte_memory_tb.sv
